>>> hdl/pmst_pkg.sv
package pmst_pkg;
    localparam int MAX_VERTICES_DEF = 32;
    localparam int ROW_W = 5;
    localparam int WEIGHT_W = 31;
    localparam int CNT_W = 6;
    localparam int VTX_W = 6;
    localparam logic [5:0] VERTEX_COUNT_RESET = 6'd32;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [ROW_W-1:0]    col;
        logic [WEIGHT_W-1:0] weight;
        logic                has_edge;
        logic                last;
    } in_item_t;

    typedef struct packed {
        logic [VTX_W-1:0] from_vertex;
        logic [VTX_W-1:0] to_vertex;
        logic             no_tree;
        logic             last_result;
    } out_item_t;
endpackage

>>> hdl/pmst_if.sv
interface pmst_in_if;
    logic               valid;
    logic               ready;
    pmst_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pmst_out_if;
    logic                valid;
    logic                ready;
    pmst_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pmst_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/prim_mst_dense_unit.sv
// Load: one matrix entry per cycle while idle; input is blocked during a run.
// A last entry starts up to N-1 steps; each step reads and relaxes one matrix
// row through the registered memory port, then selects the nearest vertex.
// Results then leave one per cycle while out_ch.ready is high, a failure
// result earlier and alone; with N of one, no result is produced.
// Reset (rst_n async low) clears control state and sets vertex_count to 32.
module prim_mst_dense_unit #(
    parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    pmst_in_if.sink         in_ch,
    pmst_out_if.source      out_ch,
    pmst_cfg_if.sink        cfg
);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = 2 * VW;
    localparam int NW = VW + 1;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SEL   = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_FAIL  = 3'd4;

    logic [2:0]    state_reg;
    logic [5:0]    vcount_reg;
    logic [NW-1:0] n_eff;

    // per-vertex state (flip-flops, MAX_VERTICES entries read at variable indices)
    logic [31:0]   dist_reg   [MAX_VERTICES];
    logic [VW-1:0] parent_reg [MAX_VERTICES];
    logic          intree_reg [MAX_VERTICES];
    logic [VW-1:0] order_reg  [MAX_VERTICES];

    logic [VW-1:0] cur_reg;
    logic [NW-1:0] tcount_reg;
    logic [NW-1:0] idx_reg;     // column issued to memory
    logic          rvld_reg;    // read data valid
    logic [VW-1:0] ridx_reg;    // column of read data
    logic [NW-1:0] sel_reg;     // selection scan index
    logic [31:0]   best_reg;
    logic [VW-1:0] pick_reg;
    logic          found_reg;
    logic [NW-1:0] emit_reg;

    // Configuration clamp
    always_comb
    begin
        if (vcount_reg == 6'd0)
            n_eff = NW'(1);
        else if (32'(vcount_reg) > MAX_VERTICES)
            n_eff = NW'(MAX_VERTICES);
        else
            n_eff = NW'(vcount_reg);
    end

    // vertex count only changes while idle
    assign cfg.ready = (state_reg == S_LOAD);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= pmst_pkg::VERTEX_COUNT_RESET;
        else if (cfg.valid && cfg.ready)
            vcount_reg <= cfg.data;
    end

    // Memory
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic          in_range;

    assign in_ch.ready = (state_reg == S_LOAD);
    assign in_range = (32'(in_ch.data.row) < MAX_VERTICES)
        && (32'(in_ch.data.col) < MAX_VERTICES);
    assign wr_en = in_ch.valid && in_ch.ready && in_range;
    assign rd_addr = {cur_reg, idx_reg[VW-1:0]};

    pmst_adj_mem #(.DEPTH(1 << AW)) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr ({VW'(in_ch.data.row), VW'(in_ch.data.col)}),
        .wr_data (in_ch.data.has_edge ? {1'b1, in_ch.data.weight} : 32'd0),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic issuing;
    assign issuing = (state_reg == S_SCAN) && (idx_reg < n_eff);

    // Output
    assign out_ch.valid = (state_reg == S_EMIT) || (state_reg == S_FAIL);
    always_comb
    begin
        out_ch.data = '0;
        if (state_reg == S_FAIL)
        begin
            out_ch.data.no_tree = 1'b1;
            out_ch.data.last_result = 1'b1;
        end
        else
        begin
            out_ch.data.to_vertex =
                pmst_pkg::VTX_W'(order_reg[emit_reg[VW-1:0]]) + 6'd1;
            out_ch.data.from_vertex =
                6'(parent_reg[order_reg[emit_reg[VW-1:0]]]) + 6'd1;
            out_ch.data.last_result = (emit_reg + NW'(1) == tcount_reg);
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            rvld_reg  <= 1'b0;
            ridx_reg  <= '0;
            cur_reg   <= '0;
            tcount_reg <= '0;
            idx_reg   <= '0;
            sel_reg   <= '0;
            emit_reg  <= '0;
            found_reg <= 1'b0;
            best_reg  <= 32'h8000_0000;
            pick_reg  <= '0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                intree_reg[i] <= 1'b0;
                dist_reg[i]   <= 32'h8000_0000;
                parent_reg[i] <= '0;
                order_reg[i]  <= '0;
            end
        end
        else
        begin
            rvld_reg <= issuing;
            ridx_reg <= idx_reg[VW-1:0];
            if (issuing)
                idx_reg <= idx_reg + NW'(1);
            // relax one column per cycle
            if (rvld_reg && rd_data[31] && !intree_reg[ridx_reg]
                && ({1'b0, rd_data[30:0]} < dist_reg[ridx_reg]))
            begin
                dist_reg[ridx_reg]   <= {1'b0, rd_data[30:0]};
                parent_reg[ridx_reg] <= cur_reg;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_ch.valid && in_ch.data.last)
                    begin
                        for (int i = 0; i < MAX_VERTICES; i++)
                        begin
                            intree_reg[i] <= 1'b0;
                            dist_reg[i]   <= (i == 0) ? 32'd0 : 32'h8000_0000;
                            parent_reg[i] <= '0;
                        end
                        cur_reg    <= '0;
                        tcount_reg <= '0;
                        idx_reg    <= '0;
                        emit_reg   <= '0;
                        state_reg  <= (n_eff == NW'(1)) ? S_LOAD : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (!issuing && !rvld_reg)
                    begin
                        intree_reg[cur_reg] <= 1'b1;
                        sel_reg   <= '0;
                        best_reg  <= 32'h8000_0000;
                        found_reg <= 1'b0;
                        state_reg <= S_SEL;
                    end
                end
                S_SEL:
                begin
                    if (sel_reg < n_eff)
                    begin
                        if (!intree_reg[sel_reg[VW-1:0]]
                            && dist_reg[sel_reg[VW-1:0]] < best_reg)
                        begin
                            best_reg  <= dist_reg[sel_reg[VW-1:0]];
                            pick_reg  <= sel_reg[VW-1:0];
                            found_reg <= 1'b1;
                        end
                        sel_reg <= sel_reg + NW'(1);
                    end
                    else if (!found_reg)
                        state_reg <= S_FAIL;
                    else
                    begin
                        cur_reg <= pick_reg;
                        order_reg[tcount_reg[VW-1:0]] <= pick_reg;
                        tcount_reg <= tcount_reg + NW'(1);
                        idx_reg <= '0;
                        state_reg <= (tcount_reg + NW'(2) >= n_eff) ? S_EMIT : S_SCAN;
                    end
                end
                S_EMIT:
                begin
                    if (out_ch.ready)
                    begin
                        emit_reg <= emit_reg + NW'(1);
                        if (emit_reg + NW'(1) == tcount_reg)
                            state_reg <= S_LOAD;
                    end
                end
                S_FAIL:
                begin
                    if (out_ch.ready)
                        state_reg <= S_LOAD;
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    // Checks
    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> !in_ch.ready)
        else $error("input taken during run");
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.no_tree) |-> out_ch.data.last_result)
        else $error("failure result not final");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tcount_reg < NW'(MAX_VERTICES))
        else $error("tree count overflow");
endmodule

>>> hdl/pmst_adj_mem.sv
// Adjacency matrix store: one write port, one registered read port.
module pmst_adj_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [31:0]              wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [31:0]              rd_data
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
